>>> src/vpr_pkg.sv
// ---------------------------------------------------------------------------
// vpr_pkg
// Types, constants and helpers shared by the visibility phase rotator.
// ---------------------------------------------------------------------------
`default_nettype none

package vpr_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int NCORR_MAX    = 4;
  localparam int NVIS         = 2 * NCORR_MAX;
  localparam int ANGLE_W      = 32;
  localparam int CW           = 34;                 // cordic x, y and z width
  localparam int PROD_W       = SAMPLE_W + CW;
  localparam int ACC_W        = PROD_W + 2;
  localparam int FRONT_STAGES = 7;
  localparam int REG_IDX_W    = 1;

  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 1'b1;

  // 2^96 * pi / (648000 * c * 1000) as an integer, split into limbs
  localparam logic [40:0] SCALE_K  = 41'd1281249614227;
  localparam logic [31:0] SCALE_KL = SCALE_K[31:0];
  localparam logic [8:0]  SCALE_KH = SCALE_K[40:32];

  localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0]         u_mm;
    logic signed [31:0]         v_mm;
    logic [27:0]                freq_khz;
    logic signed [SAMPLE_W-1:0] vis0_re;
    logic signed [SAMPLE_W-1:0] vis0_im;
    logic signed [SAMPLE_W-1:0] vis1_re;
    logic signed [SAMPLE_W-1:0] vis1_im;
    logic signed [SAMPLE_W-1:0] vis2_re;
    logic signed [SAMPLE_W-1:0] vis2_im;
    logic signed [SAMPLE_W-1:0] vis3_re;
    logic signed [SAMPLE_W-1:0] vis3_im;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out0_re;
    logic signed [SAMPLE_W-1:0] out0_im;
    logic signed [SAMPLE_W-1:0] out1_re;
    logic signed [SAMPLE_W-1:0] out1_im;
    logic signed [SAMPLE_W-1:0] out2_re;
    logic signed [SAMPLE_W-1:0] out2_im;
    logic signed [SAMPLE_W-1:0] out3_re;
    logic signed [SAMPLE_W-1:0] out3_im;
  } out_item_t;

  // even entries real, odd entries imaginary
  typedef logic [NVIS-1:0][SAMPLE_W-1:0] vis_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    vis_t               vis;
  } job_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9:  r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
      15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
      21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
      24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
      27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Q30 accumulator: round half up, then saturate to a sample
  function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] sh;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    lo = -hi - ACC_W'(1);
    t  = acc + ACC_W'(64'sd1 <<< 29);
    sh = t >>> 30;
    if (sh > hi) begin
      sh = hi;
    end else if (sh < lo) begin
      sh = lo;
    end
    return sh[SAMPLE_W-1:0];
  endfunction

  // edges from the accepting edge to the edge that takes the result
  function automatic int latency(input int steps);
    return FRONT_STAGES + 4 + steps;
  endfunction

endpackage

`default_nettype wire

>>> src/vpr_phase.sv
// ---------------------------------------------------------------------------
// vpr_phase
// Front end: forms the phase angle of each item as a 32-bit turn fraction.
// ---------------------------------------------------------------------------
`default_nettype none

module vpr_phase import vpr_pkg::*; #(
  parameter int PHASE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire in_item_t           item,
  input  wire logic signed [31:0] offset_x,
  input  wire logic signed [31:0] offset_y,
  output logic                    job_valid,
  output job_t                    job
);

  localparam int DROP = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;
  localparam logic [31:0] AMASK = 32'(~((33'd1 << DROP) - 33'd1));

  logic [FRONT_STAGES-1:0] valid;
  vis_t vis [0:FRONT_STAGES-1];

  logic signed [63:0] pu1, pv1;
  logic [27:0] f1, f2;
  logic signed [64:0] s2;
  logic [60:0] lo3;
  logic signed [60:0] hi3;
  logic [95:0] t4;
  logic [63:0] m00, m10;
  logic [31:0] m20, m11;
  logic [40:0] m01;
  logic [95:0] a6, b6;
  logic [95:0] p7;
  logic [31:0] angle7;
  logic [63:0] m20_full, m11_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[FRONT_STAGES-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    vis[0] <= {item.vis3_im, item.vis3_re, item.vis2_im, item.vis2_re,
               item.vis1_im, item.vis1_re, item.vis0_im, item.vis0_re};
    for (int i = 1; i < FRONT_STAGES; i++) begin
      vis[i] <= vis[i-1];
    end
  end

  assign m20_full = 64'(t4[95:64]) * 64'(SCALE_KL);
  assign m11_full = 64'(t4[63:32]) * 64'(SCALE_KH);
  assign angle7   = p7[95:64] & AMASK;

  always_ff @(posedge clk) begin
    // baseline dot offset
    pu1 <= item.u_mm * offset_x;
    pv1 <= item.v_mm * offset_y;
    f1  <= item.freq_khz;
    s2  <= {pu1[63], pu1} + {pv1[63], pv1};
    f2  <= f1;
    // times frequency, in two partial products
    lo3 <= 61'(s2[32:0]) * 61'(f2);
    hi3 <= $signed(s2[64:33]) * $signed({1'b0, f2});
    t4  <= 96'(lo3) + ({{35{hi3[60]}}, hi3} << 33);
    // times scale, modulo 2^96, then negated
    m00 <= 64'(t4[31:0]) * 64'(SCALE_KL);
    m10 <= 64'(t4[63:32]) * 64'(SCALE_KL);
    m20 <= m20_full[31:0];
    m01 <= 41'(t4[31:0]) * 41'(SCALE_KH);
    m11 <= m11_full[31:0];
    a6  <= 96'(m00) + (96'(m10) << 32);
    b6  <= {m20, 64'd0} + {m11, 64'd0} + (96'(m01) << 32);
    p7  <= 96'(0) - (a6 + b6);
  end

  assign job_valid = valid[FRONT_STAGES-1];
  assign job.angle = angle7;
  assign job.vis   = vis[FRONT_STAGES-1];

endmodule

`default_nettype wire

>>> src/vpr_queue.sv
// ---------------------------------------------------------------------------
// vpr_queue
// Two-entry queue between the phase front end and the rotation back end.
// ---------------------------------------------------------------------------
`default_nettype none

module vpr_queue import vpr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head
);

  job_t mem [0:1];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic do_push, do_pop;

  assign do_pop  = pop && (count != 2'd0);
  assign do_push = push && ((count != 2'd2) || do_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

endmodule

`default_nettype wire

>>> src/vpr_rotate.sv
// ---------------------------------------------------------------------------
// vpr_rotate
// Back end: pipelined cordic for cos and sin, then complex rotation of
// the samples of the first NUM_CORR correlations with rounding and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module vpr_rotate import vpr_pkg::*; #(
  parameter int NUM_CORR     = 4,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      res_valid,
  output vis_t      res
);

  localparam int NS = CORDIC_STEPS;

  logic [NS+2:0] valid;
  logic signed [CW-1:0] cx [0:NS];
  logic signed [CW-1:0] cy [0:NS];
  logic signed [CW-1:0] cz [0:NS];
  logic [1:0] cq [0:NS];
  vis_t cv [0:NS];

  logic [31:0] round_a, rem_a;
  logic [1:0] q_a;
  logic signed [CW-1:0] c_w, s_w;

  logic signed [PROD_W-1:0] pac [0:NCORR_MAX-1];
  logic signed [PROD_W-1:0] pbs [0:NCORR_MAX-1];
  logic signed [PROD_W-1:0] pas [0:NCORR_MAX-1];
  logic signed [PROD_W-1:0] pbc [0:NCORR_MAX-1];
  vis_t out_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[NS+1:0], job_valid};
    end
  end

  // nearest quarter turn, residue in [-1/8, 1/8) turn
  assign round_a = job.angle + 32'h2000_0000;
  assign q_a     = round_a[31:30];
  assign rem_a   = job.angle - {q_a, 30'd0};

  always_ff @(posedge clk) begin
    cx[0] <= INV_GAIN;
    cy[0] <= '0;
    cz[0] <= {{(CW-32){rem_a[31]}}, rem_a};
    cq[0] <= q_a;
    cv[0] <= job.vis;
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!cz[i][CW-1]) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - $signed(CW'(atan_turn(i)));
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + $signed(CW'(atan_turn(i)));
      end
      cq[i+1] <= cq[i];
      cv[i+1] <= cv[i];
    end
  end

  always_comb begin
    case (cq[NS])
      2'd0: begin
        c_w = cx[NS];
        s_w = cy[NS];
      end
      2'd1: begin
        c_w = -cy[NS];
        s_w = cx[NS];
      end
      2'd2: begin
        c_w = -cx[NS];
        s_w = -cy[NS];
      end
      default: begin
        c_w = cy[NS];
        s_w = -cx[NS];
      end
    endcase
  end

  // correlations beyond NUM_CORR read as zero
  always_ff @(posedge clk) begin
    for (int k = 0; k < NCORR_MAX; k++) begin
      if (k < NUM_CORR) begin
        pac[k] <= $signed(cv[NS][2*k])   * c_w;
        pbs[k] <= $signed(cv[NS][2*k+1]) * s_w;
        pas[k] <= $signed(cv[NS][2*k])   * s_w;
        pbc[k] <= $signed(cv[NS][2*k+1]) * c_w;
        out_r[2*k]   <= round_sat(ACC_W'(pac[k]) - ACC_W'(pbs[k]));
        out_r[2*k+1] <= round_sat(ACC_W'(pas[k]) + ACC_W'(pbc[k]));
      end else begin
        pac[k] <= '0;
        pbs[k] <= '0;
        pas[k] <= '0;
        pbc[k] <= '0;
        out_r[2*k]   <= '0;
        out_r[2*k+1] <= '0;
      end
    end
  end

  assign res_valid = valid[NS+2];
  assign res       = out_r;

endmodule

`default_nettype wire

>>> src/visibility_phase_rotator.sv
// Pipeline: 7 phase stages, the queue, one cordic stage per step and three
// rotation stages lie between the start transfer and the done strobe.
// Throughput: one item per cycle while busy is low; every stage is fully pipelined.
// Reset: synchronous, clears both offsets and all valid flags; busy is high
// while reset is held. Results leave on a one-cycle done strobe.
// ---------------------------------------------------------------------------
// visibility_phase_rotator
// Shifts the phase centre of visibilities by the configured sky offsets.
// ---------------------------------------------------------------------------
`default_nettype none

module visibility_phase_rotator import vpr_pkg::*; #(
  parameter int NUM_CORR     = 4,
  parameter int PHASE_BITS   = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             in_item,
  output logic                      done,
  output out_item_t                 result,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] wr_index,
  input  wire logic [31:0]          wr_data
);

  logic signed [31:0] offset_x, offset_y;
  logic front_valid, head_valid;
  job_t front_job, head_job;
  vis_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_OFFSET_X: offset_x <= wr_data;
        REG_OFFSET_Y: offset_y <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  vpr_phase #(.PHASE_BITS(PHASE_BITS)) u_phase (
    .clk       (clk),
    .rst       (rst),
    .take      (start && !busy),
    .item      (in_item),
    .offset_x  (offset_x),
    .offset_y  (offset_y),
    .job_valid (front_valid),
    .job       (front_job)
  );

  // back end never stalls, so the head is drained every cycle
  vpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_valid),
    .push_job   (front_job),
    .pop        (1'b1),
    .head_valid (head_valid),
    .head       (head_job)
  );

  vpr_rotate #(.NUM_CORR(NUM_CORR), .CORDIC_STEPS(CORDIC_STEPS)) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .res_valid (done),
    .res       (res)
  );

  assign result.out0_re = res[0];
  assign result.out0_im = res[1];
  assign result.out1_re = res[2];
  assign result.out1_im = res[3];
  assign result.out2_re = res[4];
  assign result.out2_im = res[5];
  assign result.out3_re = res[6];
  assign result.out3_im = res[7];

endmodule

`default_nettype wire

>>> src/vpr_checker.sv
// ---------------------------------------------------------------------------
// vpr_checker
// Port-level checks on the rotator: strobe timing, no stall and zero passthrough.
// ---------------------------------------------------------------------------
`default_nettype none

module vpr_checker import vpr_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_item,
  input wire logic      done,
  input wire out_item_t result
);

  localparam int LAT = latency(CORDIC_STEPS);

  logic zero_in;
  assign zero_in = (in_item.vis0_re == '0) && (in_item.vis0_im == '0) &&
                   (in_item.vis1_re == '0) && (in_item.vis1_im == '0) &&
                   (in_item.vis2_re == '0) && (in_item.vis2_im == '0) &&
                   (in_item.vis3_re == '0) && (in_item.vis3_im == '0);

  a_no_stall: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy outside reset");

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("done without a matching start transfer");

  a_zero_through: assert property (@(posedge clk) disable iff (rst)
    done && $past(zero_in, LAT) |-> (result == '0))
    else $error("zero samples did not rotate to zero");

endmodule

bind visibility_phase_rotator vpr_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_vpr_checker (.*);

`default_nettype wire
